### rtl/spi_baud_divider_search_macros.svh
// Assertion helpers used by sbds_ctrl.
`ifndef SPI_BAUD_DIVIDER_SEARCH_MACROS_SVH
`define SPI_BAUD_DIVIDER_SEARCH_MACROS_SVH

// Same-cycle implication, cleared during reset.
`define SBDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, cleared during reset.
`define SBDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sbds_pkg.sv
package sbds_pkg;

  localparam int unsigned DIV_BITS  = 18;   // largest divisor 7 * 32768
  localparam int unsigned PAIR_BITS = 6;    // 4 prescalers x 16 scalers

  localparam logic [31:0] CORE_CLOCK_RESET = 32'd120000000;
  localparam logic [31:0] ERR_INIT         = 32'hFFFF_FFFF;
  localparam logic [PAIR_BITS-1:0] LAST_PAIR = '1;

  localparam logic [2:0] PRESCALER [4] = '{3'd2, 3'd3, 3'd5, 3'd7};
  localparam logic [15:0] SCALER [16] = '{
    16'd2, 16'd4, 16'd6, 16'd8, 16'd16, 16'd32, 16'd64, 16'd128,
    16'd256, 16'd512, 16'd1024, 16'd2048, 16'd4096, 16'd8192, 16'd16384, 16'd32768
  };

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture target, pick effective clock, clear best
    logic div_init;  // load dividend and divisor for current pair
    logic div_step;  // one restoring division step
    logic calc_err;  // absolute error of the quotient
    logic update;    // keep pair if better, advance to next pair
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_last;   // current step is the final quotient bit
    logic exact;      // error register holds zero
    logic last_pair;  // current pair is the final one
  } sts_t;

endpackage

### rtl/sbds_datapath.sv
module sbds_datapath
  import sbds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic [31:0] target_baud,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [3:0]  scaler_index,
  output logic [1:0]  prescaler_index,
  output logic        double_rate
);

  logic [31:0]          core_clock_hz;
  logic [31:0]          target;
  logic [31:0]          clk_eff;
  logic                 dbl;
  logic [31:0]          quo;
  logic [DIV_BITS-1:0]  rem;
  logic [DIV_BITS-1:0]  divisor;
  logic [4:0]           cnt;
  logic [31:0]          err;
  logic [31:0]          best_err;
  logic [PAIR_BITS-1:0] pair;
  logic [PAIR_BITS-1:0] best_pair;

  logic [DIV_BITS:0]    trial;
  logic                 ge;
  logic [DIV_BITS:0]    diff;
  logic [18:0]          product;

  assign trial   = {rem, quo[31]};
  assign ge      = trial >= {1'b0, divisor};
  assign diff    = trial - {1'b0, divisor};
  assign product = 19'(PRESCALER[pair[5:4]]) * 19'(SCALER[pair[3:0]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock_hz <= CORE_CLOCK_RESET;
    end else if (cfg_we) begin
      core_clock_hz <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target    <= target_baud;
      dbl       <= target_baud > {3'b000, core_clock_hz[31:3]};
      clk_eff   <= (target_baud > {3'b000, core_clock_hz[31:3]}) ?
                   core_clock_hz : {1'b0, core_clock_hz[31:1]};
      best_err  <= ERR_INIT;
      best_pair <= '0;
      pair      <= '0;
    end
    if (cmd.div_init) begin
      quo     <= clk_eff;
      rem     <= '0;
      divisor <= product[DIV_BITS-1:0];
      cnt     <= '0;
    end
    if (cmd.div_step) begin
      // shift quotient bits in where dividend bits leave
      quo <= {quo[30:0], ge};
      rem <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      cnt <= cnt + 5'd1;
    end
    if (cmd.calc_err) begin
      err <= (target > quo) ? (target - quo) : (quo - target);
    end
    if (cmd.update) begin
      // strict compare: ties keep the earlier pair
      if (err < best_err) begin
        best_err  <= err;
        best_pair <= pair;
      end
      pair <= pair + 1'b1;
    end
  end

  assign sts.div_last  = cnt == 5'd31;
  assign sts.exact     = err == '0;
  assign sts.last_pair = pair == LAST_PAIR;

  assign scaler_index    = best_pair[3:0];
  assign prescaler_index = best_pair[5:4];
  assign double_rate     = dbl;

endmodule

### rtl/sbds_ctrl.sv
`include "spi_baud_divider_search_macros.svh"

module sbds_ctrl
  import sbds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_DIV,
    S_ERR,
    S_UPD
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) state <= S_INIT;
        end
        S_INIT: state <= S_DIV;
        S_DIV: begin
          if (sts.div_last) state <= S_ERR;
        end
        S_ERR: state <= S_UPD;
        S_UPD: begin
          // stop on an exact match or after the final pair
          if (sts.exact || sts.last_pair) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_INIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    // capture the target on the accepting edge, while it is still on the port
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && start;
    cmd.div_init = state == S_INIT;
    cmd.div_step = state == S_DIV;
    cmd.calc_err = state == S_ERR;
    cmd.update   = state == S_UPD;
  end

  assign busy = state != S_IDLE;

  `SBDS_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for more than one cycle")
  `SBDS_ASSERT_NEXT(a_start_loads, start && !busy, state == S_INIT, "accepted transfer did not load")
  `SBDS_ASSERT_NEXT(a_div_ends, state == S_DIV && sts.div_last, state == S_ERR, "division overran")
  `SBDS_ASSERT_NOW(a_done_idle, done, state == S_IDLE, "result strobe outside idle")

endmodule

### rtl/spi_baud_divider_search.sv
// Tries prescaler/scaler pairs in turn, up to 64 pairs, fewer when an exact match ends
// the search early; each pair is loaded, divided, its error taken, then kept if better.
// One transfer at a time; the next is taken in the strobe cycle.
// A 32-step restoring divider is shared by all pairs.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous active-high reset returns to idle and sets core_clock_hz to 120000000.
module spi_baud_divider_search
  import sbds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] target_baud,
  output logic        done,
  output logic [3:0]  scaler_index,
  output logic [1:0]  prescaler_index,
  output logic        double_rate
);

  cmd_t cmd;
  sts_t sts;

  sbds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  sbds_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .target_baud     (target_baud),
    .cmd             (cmd),
    .sts             (sts),
    .scaler_index    (scaler_index),
    .prescaler_index (prescaler_index),
    .double_rate     (double_rate)
  );

endmodule
